[design/pstg_pkg.sv]
// Shared constants and codes for the square tone generator.
package pstg_pkg;

  localparam int ModeW   = 2;
  localparam int ByteW   = 8;
  localparam int PeriodW = 16;
  localparam int ScaledW = 22;
  localparam int PhaseW  = 23;
  localparam int MulW    = 6;

  localparam logic [ModeW-1:0] MODE_LOAD    = 2'd0;
  localparam logic [ModeW-1:0] MODE_ENABLE  = 2'd1;
  localparam logic [ModeW-1:0] MODE_DISABLE = 2'd2;
  localparam logic [ModeW-1:0] MODE_TICK    = 2'd3;

  localparam logic [ByteW-1:0]   TONE_HIGH  = 8'hBF;
  localparam logic [ByteW-1:0]   TONE_LOW   = 8'h80;
  localparam logic [MulW-1:0]    PERIOD_MUL = 6'd49;
  localparam logic [PhaseW:0]    PHASE_STEP = 24'd2048;
  localparam logic [PhaseW-1:0]  PHASE_MAX  = 23'h7FFFFF;

  typedef logic [ModeW-1:0] mode_t;

endpackage

[design/pstg_tone.sv]
// Tone state: period loading, enable and per-tick phase update.
module pstg_tone (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  pstg_pkg::mode_t           mode,
  input  logic [pstg_pkg::ByteW-1:0] data_byte,
  output logic [pstg_pkg::ByteW-1:0] sample
);
  import pstg_pkg::*;

  logic                expect_low_byte;
  logic [ByteW-1:0]    held_low_byte;
  logic [ScaledW-1:0]  scaled_period;
  logic                tone_enabled;
  logic [PhaseW-1:0]   phase;
  logic [PhaseW-1:0]   phase_next;
  logic [ScaledW-1:0]  scaled_next;
  logic [PhaseW:0]     stepped;
  logic [PhaseW:0]     wrapped;
  logic                sounding;

  assign sounding = tone_enabled && (scaled_period != '0);
  assign sample   = (sounding && ({phase, 1'b0} < {2'b00, scaled_period})) ? TONE_HIGH
                                                                            : TONE_LOW;

  assign scaled_next = ScaledW'({data_byte, held_low_byte}) * ScaledW'(PERIOD_MUL);

  always_comb begin
    stepped = {1'b0, phase} + PHASE_STEP;
    if (stepped >= {2'b00, scaled_period}) begin
      wrapped = stepped - {2'b00, scaled_period};
    end else begin
      wrapped = stepped;
    end
    if (wrapped[PhaseW]) begin
      phase_next = PHASE_MAX;
    end else begin
      phase_next = wrapped[PhaseW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_low_byte <= 1'b1;
      held_low_byte   <= '0;
      scaled_period   <= '0;
      tone_enabled    <= 1'b0;
      phase           <= '0;
    end else if (step) begin
      case (mode)
        MODE_LOAD: begin
          if (expect_low_byte) begin
            held_low_byte <= data_byte;
          end else begin
            scaled_period <= scaled_next;
          end
          expect_low_byte <= !expect_low_byte;
        end
        MODE_ENABLE: begin
          tone_enabled <= 1'b1;
          phase        <= '0;
        end
        MODE_DISABLE: begin
          tone_enabled <= 1'b0;
        end
        MODE_TICK: begin
          if (sounding) begin
            phase <= phase_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/programmable_square_tone_generator_core.sv]
// Top level of the programmable square tone generator.
//
// Input stream: each transfer carries one command. tuser selects it: load a
// period byte (low byte, then high byte), enable the tone (phase cleared),
// disable the tone, or a sample tick. tdata holds the period byte; tlast on
// a tick marks the last sample of a host buffer.
// Output stream: one transfer per tick, an 8-bit sample (0xBF high, 0x80
// low or silent) in tdata, with tlast copied from the tick.
// A tick's sample is registered and appears in the cycle after its input
// transfer. Throughput: one command per cycle while the output is not stalled;
// the phase update is one add, one compare and subtract, done combinationally
// ahead of the phase register. When the receiver stalls with a sample waiting,
// input tready drops until that sample is taken, so no tick is lost.
// Reset: synchronous; period zero (silent), tone disabled, phase zero,
// low byte expected next, output empty.
module programmable_square_tone_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  input  logic        s_axis_tlast,   // buffer_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] sample
  output logic        m_axis_tlast    // last_sample
);
  import pstg_pkg::*;

  logic              in_xfer;
  logic              is_tick;
  logic [ByteW-1:0]  tone_sample;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (s_axis_tuser == MODE_TICK);

  pstg_tone u_tone (
    .clk       (clk),
    .rst       (rst),
    .step      (in_xfer),
    .mode      (s_axis_tuser),
    .data_byte (s_axis_tdata),
    .sample    (tone_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_xfer && is_tick) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && is_tick) begin
      m_axis_tdata <= tone_sample;
      m_axis_tlast <= s_axis_tlast;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && m_axis_tvalid) |-> m_axis_tready)
    else $error("input taken while a stalled sample waits");

  a_tick_yields: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && is_tick) |=> m_axis_tvalid)
    else $error("tick did not produce a sample");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !is_tick) |=> !m_axis_tvalid)
    else $error("sample produced without a tick");

  a_sample_level: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata == TONE_HIGH || m_axis_tdata == TONE_LOW))
    else $error("sample level out of range");

endmodule
